// ----- sv/wheel_odometry_pose_update_assert.svh -----
// ============================================================================
// Wheel odometry pose update: assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ============================================================================
`ifndef WHEEL_ODOMETRY_POSE_UPDATE_ASSERT_SVH
`define WHEEL_ODOMETRY_POSE_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define WOPU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle
`define WOPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WOPU_ASSERT(label, clk, rst_n, prop, msg)
`define WOPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/wopu_pkg.sv -----
// ============================================================================
// Wheel odometry pose update: package
// Sequencer states, codes, widths and the CORDIC arctangent table.
// ============================================================================
package wopu_pkg;

  // Operand and product widths of the shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  // Item opcodes
  localparam logic OP_UPDATE   = 1'b0;
  localparam logic OP_SET_POSE = 1'b1;

  // Register indexes (byte address bit 2)
  localparam logic REG_IDX_MIDDLE = 1'b0;
  localparam logic REG_IDX_GAIN   = 1'b1;

  // Quadrant codes from the top two bits of a 32-bit turn
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // CORDIC start value, pre-scaled by the inverse gain, Q2.30
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // Rounding constant for Q24.8 x Q2.30 products
  localparam logic signed [63:0] ROUND_Q30 = 64'sh0000_0000_2000_0000;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MLO,
    ST_MHI,
    ST_ANG,
    ST_ST1,
    ST_W1,
    ST_ST2,
    ST_W2,
    ST_PM0,
    ST_PM1,
    ST_PM2,
    ST_PM3,
    ST_PM4,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ----- sv/wopu_mul.sv -----
// ============================================================================
// Wheel odometry pose update: shared multiplier
// Signed 33 x 33 multiplier with a registered product.
// ============================================================================
module wopu_mul
  import wopu_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  // Form the full product
  assign prod_nxt = op_a * op_b;

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- sv/wopu_cordic.sv -----
// ============================================================================
// Wheel odometry pose update: iterative CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, sine and cosine Q2.30.
// ============================================================================
module wopu_cordic
  import wopu_pkg::*;
#(
  parameter int ANGLE_BITS      = 24,
  parameter int TRIG_ITERATIONS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done_r,
  output logic signed [31:0]    sin_q30,
  output logic signed [31:0]    cos_q30
);

  localparam int CNT_W = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TRIG_ITERATIONS - 1);

  logic [31:0]        turn32;
  logic signed [31:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [31:0] x_sh, y_sh, atan_step;
  logic [1:0]         quad_r, quad_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_nxt, last_step;

  // Scale the angle to 2^32 per turn
  assign turn32    = 32'(angle) << (32 - ANGLE_BITS);
  assign last_step = busy_r && (cnt_r == CNT_LAST);

  // One micro-rotation, or load a new angle
  always_comb begin
    x_sh      = x_r >>> cnt_r;
    y_sh      = y_r >>> cnt_r;
    atan_step = $signed(ATAN_TURNS[5'(cnt_r)]);
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    quad_nxt  = quad_r;
    if (start) begin
      x_nxt    = CORDIC_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = $signed({2'b00, turn32[29:0]});
      quad_nxt = turn32[31:30];
    end else if (busy_r) begin
      if (!z_r[31]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - atan_step;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + atan_step;
      end
    end
  end

  // Advance the iteration count
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = last_step;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (last_step) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
  end

  // Fold the first-quadrant result back into the full turn
  always_comb begin
    case (quad_r)
      QUAD_0: begin
        cos_q30 = x_r;
        sin_q30 = y_r;
      end
      QUAD_1: begin
        cos_q30 = -y_r;
        sin_q30 = x_r;
      end
      QUAD_2: begin
        cos_q30 = -x_r;
        sin_q30 = -y_r;
      end
      QUAD_3: begin
        cos_q30 = y_r;
        sin_q30 = -x_r;
      end
      default: begin
        cos_q30 = x_r;
        sin_q30 = y_r;
      end
    endcase
  end

endmodule

// ----- sv/wheel_odometry_pose_update.sv -----
// An update word is taken only while the sequencer is idle and gives its pose after two
//   passes through the one CORDIC unit and six passes through the multiplier; a set-pose
//   word goes straight to the result word. The next word is taken once the result word is
//   loaded, which waits while the result channel holds an untaken word.
// Reset: rst_n low at a clock edge clears pose, readings, registers and handshakes;
//   there is no clearing pass.
// ============================================================================
// Wheel odometry pose update
// Integrates a differential-drive pose from cumulative wheel distances.
// ============================================================================
`include "wheel_odometry_pose_update_assert.svh"
module wheel_odometry_pose_update
  import wopu_pkg::*;
#(
  parameter int ANGLE_BITS      = 24,
  parameter int TRIG_ITERATIONS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic signed [31:0]    in_dist_left,
  input  logic signed [31:0]    in_dist_right,
  input  logic signed [31:0]    in_dist_middle,
  input  logic signed [31:0]    in_new_x,
  input  logic signed [31:0]    in_new_y,
  input  logic [ANGLE_BITS-1:0] in_new_heading,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_pose_x,
  output logic signed [31:0]    out_pose_y,
  output logic [ANGLE_BITS-1:0] out_pose_heading,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  state_t state_r, state_nxt;

  logic                  middle_r;
  logic [31:0]           gain_r;
  logic [31:0]           last_left_r, last_right_r, last_middle_r;
  logic signed [31:0]    pos_x_r, pos_y_r;
  logic [ANGLE_BITS-1:0] heading_r;
  logic signed [32:0]    diff_r;
  logic signed [31:0]    ds_r, dm_r;
  logic signed [63:0]    acc_r;
  logic [ANGLE_BITS:0]   da_r;
  logic signed [31:0]    s1_r, c1_r, s2_r, c2_r;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [31:0]    pose_x_r, pose_y_r;
  logic [ANGLE_BITS-1:0] pose_heading_r;

  logic                  in_acc, cfg_wr, out_load;
  logic signed [31:0]    dl, dr, dm;
  logic signed [32:0]    sum33, diff33;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [63:0]    prod64, ang_sum;
  logic [ANGLE_BITS-1:0] half_da;
  logic                  cor_start, cor_done;
  logic [ANGLE_BITS-1:0] cor_angle;
  logic signed [31:0]    cor_sin, cor_cos;

  // Saturate a 35-bit sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Add a rounded Q30 accumulation to a position
  function automatic logic signed [31:0] pos_add(input logic signed [31:0] p,
                                                 input logic signed [63:0] a);
    logic signed [33:0] d;
    logic signed [34:0] s;
    d = a[63:30];
    s = {{3{p[31]}}, p} + {d[33], d};
    return sat32(s);
  endfunction

  // Handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign out_pose_x       = pose_x_r;
  assign out_pose_y       = pose_y_r;
  assign out_pose_heading = pose_heading_r;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IDX_GAIN) ? gain_r : {31'b0, middle_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      middle_r <= 1'b0;
      gain_r   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDX_GAIN) begin
        gain_r <= pwdata;
      end else begin
        middle_r <= pwdata[0];
      end
    end
  end

  // Wheel deltas against the latched readings, wrapped to 32 bits
  always_comb begin
    dl     = in_dist_left - last_left_r;
    dr     = in_dist_right - last_right_r;
    dm     = middle_r ? (in_dist_middle - last_middle_r) : '0;
    sum33  = {dl[31], dl} + {dr[31], dr};
    diff33 = {dr[31], dr} - {dl[31], dl};
  end

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MLO: begin
        mul_a = diff_r;
        mul_b = $signed({17'b0, gain_r[15:0]});
      end
      ST_MHI: begin
        mul_a = diff_r;
        mul_b = $signed({17'b0, gain_r[31:16]});
      end
      ST_PM0: begin
        mul_a = {ds_r[31], ds_r};
        mul_b = {s1_r[31], s1_r};
      end
      ST_PM1: begin
        mul_a = {dm_r[31], dm_r};
        mul_b = {c2_r[31], c2_r};
      end
      ST_PM2: begin
        mul_a = {ds_r[31], ds_r};
        mul_b = {c1_r[31], c1_r};
      end
      ST_PM3: begin
        mul_a = {dm_r[31], dm_r};
        mul_b = {s2_r[31], s2_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wopu_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign prod64  = prod_r[63:0];
  assign ang_sum = acc_r + (prod64 <<< 16);
  assign half_da = da_r[ANGLE_BITS:1];

  // Drive the CORDIC with the mid-arc heading, then the half change
  assign cor_start = (state_r == ST_ST1) || (state_r == ST_ST2);
  assign cor_angle = (state_r == ST_ST1) ? (heading_r + half_da) : half_da;

  wopu_cordic #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (cor_angle),
    .done_r  (cor_done),
    .sin_q30 (cor_sin),
    .cos_q30 (cor_cos)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_opcode == OP_SET_POSE) ? ST_OUT : ST_MLO;
        end
      end
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_ANG;
      ST_ANG:  state_nxt = ST_ST1;
      ST_ST1:  state_nxt = ST_W1;
      ST_W1: begin
        if (cor_done) begin
          state_nxt = ST_ST2;
        end
      end
      ST_ST2:  state_nxt = ST_W2;
      ST_W2: begin
        if (cor_done) begin
          state_nxt = ST_PM0;
        end
      end
      ST_PM0:  state_nxt = ST_PM1;
      ST_PM1:  state_nxt = ST_PM2;
      ST_PM2:  state_nxt = ST_PM3;
      ST_PM3:  state_nxt = ST_PM4;
      ST_PM4:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result word valid: set on load, drop once taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      last_left_r   <= '0;
      last_right_r  <= '0;
      last_middle_r <= '0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      heading_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        last_left_r  <= in_dist_left;
        last_right_r <= in_dist_right;
        if (in_opcode == OP_SET_POSE) begin
          last_middle_r <= middle_r ? in_dist_middle : '0;
          pos_x_r       <= in_new_x;
          pos_y_r       <= in_new_y;
          heading_r     <= in_new_heading;
        end else if (middle_r) begin
          last_middle_r <= in_dist_middle;
        end
      end
      if (state_r == ST_PM3) begin
        pos_x_r <= pos_add(pos_x_r, acc_r);
      end
      if (state_r == ST_FIN) begin
        pos_y_r   <= pos_add(pos_y_r, acc_r);
        heading_r <= heading_r + da_r[ANGLE_BITS-1:0];
      end
    end
  end

  // Working registers of the update
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ds_r   <= sum33[32:1];
      diff_r <= diff33;
      dm_r   <= dm;
    end
    case (state_r)
      ST_MHI: acc_r <= prod64;
      ST_ANG: da_r  <= ang_sum[24+ANGLE_BITS:24];
      ST_PM1: acc_r <= prod64 + ROUND_Q30;
      ST_PM2: acc_r <= acc_r + prod64;
      ST_PM3: acc_r <= prod64 + ROUND_Q30;
      ST_PM4: acc_r <= acc_r + prod64;
      default: begin
      end
    endcase
    if ((state_r == ST_W1) && cor_done) begin
      s1_r <= cor_sin;
      c1_r <= cor_cos;
    end
    if ((state_r == ST_W2) && cor_done) begin
      s2_r <= cor_sin;
      c2_r <= cor_cos;
    end
  end

  // Result word registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      pose_x_r       <= pos_x_r;
      pose_y_r       <= pos_y_r;
      pose_heading_r <= heading_r;
    end
  end

  // Assertions
  `WOPU_ASSERT(a_cordic_done_waited, clk, rst_n, !cor_done || (state_r == ST_W1) || (state_r == ST_W2), "CORDIC finished outside a wait step")
  `WOPU_ASSERT_NEXT(a_set_pose_load, clk, rst_n, in_acc && (in_opcode == OP_SET_POSE), (state_r == ST_OUT) && (pos_x_r == $past(in_new_x)), "set pose not loaded")
  `WOPU_ASSERT_NEXT(a_heading_advance, clk, rst_n, state_r == ST_FIN, heading_r == ($past(heading_r) + $past(da_r[ANGLE_BITS-1:0])), "heading not advanced by its change")
  `WOPU_ASSERT_NEXT(a_result_load, clk, rst_n, out_load, out_valid_r && (pose_x_r == $past(pos_x_r)), "result word not loaded")

endmodule
